>>> hdl/playfair_digraph_cipher_assert.svh
// ----------------------------------------------------------------------------
// Playfair cipher assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef PLAYFAIR_DIGRAPH_CIPHER_ASSERT_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define PFC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pfc assertion failed");

// Next-cycle implication, checked outside reset
`define PFC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pfc assertion failed");

`endif

>>> hdl/pfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Playfair cipher package
// Key square types, letter constants, rule codes and small helpers.
// ----------------------------------------------------------------------------
package pfc_pkg;

    localparam int SQ_DIM  = 5;
    localparam int CODE_W  = 5;
    localparam int IDX_W   = 3;
    localparam int ROW_W   = SQ_DIM * CODE_W;
    localparam int CHAR_W  = 8;
    localparam int CFG_IDX_W = 3;

    localparam logic [IDX_W-1:0]  IDX_LAST   = IDX_W'(SQ_DIM - 1);
    localparam logic [CHAR_W-1:0] ASCII_BASE = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_X     = 8'h58;
    localparam logic [CHAR_W-1:0] CHAR_J     = 8'h4A;
    localparam logic [CHAR_W-1:0] CHAR_I     = 8'h49;

    typedef logic [SQ_DIM-1:0][CODE_W-1:0] t_row;
    typedef t_row [SQ_DIM-1:0]             t_square;

    typedef enum logic [1:0] {
        RULE_ROW  = 2'd0,
        RULE_COL  = 2'd1,
        RULE_RECT = 2'd2,
        RULE_NONE = 2'd3
    } t_rule;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } t_loc;

    typedef struct packed {
        logic [CHAR_W-1:0] first;
        logic [CHAR_W-1:0] second;
        t_rule             rule;
    } t_result;

    // ASCII byte that a cell code stands for
    function automatic logic [CHAR_W-1:0] cell_char(input logic [CODE_W-1:0] code);
        cell_char = ASCII_BASE + {{(CHAR_W-CODE_W){1'b0}}, code};
    endfunction

    // Step forward with wrap over the square dimension
    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx);
        wrap_inc = (idx == IDX_LAST) ? '0 : idx + IDX_W'(1);
    endfunction

    // Step back with wrap over the square dimension
    function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] idx);
        wrap_dec = (idx == '0) ? IDX_LAST : idx - IDX_W'(1);
    endfunction

endpackage

>>> hdl/pfc_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Playfair letter locator lane
// Compares one letter against all 25 cells and returns the first match in
// row-major order.
// ----------------------------------------------------------------------------
module pfc_lane (
    input  pfc_pkg::t_square             i_square,
    input  logic [pfc_pkg::CHAR_W-1:0]   i_letter,
    output pfc_pkg::t_loc                o_loc
);
    import pfc_pkg::*;

    logic [SQ_DIM-1:0][SQ_DIM-1:0] hit;
    logic [SQ_DIM-1:0]             row_hit;
    logic [SQ_DIM-1:0][IDX_W-1:0]  row_col;

    // Compare the letter with every cell
    always_comb begin
        for (int r = 0; r < SQ_DIM; r++) begin
            for (int c = 0; c < SQ_DIM; c++) begin
                hit[r][c] = (cell_char(i_square[r][c]) == i_letter);
            end
        end
    end

    // Pick the leftmost hit within each row
    always_comb begin
        for (int r = 0; r < SQ_DIM; r++) begin
            row_hit[r] = |hit[r];
            row_col[r] = '0;
            for (int c = SQ_DIM - 1; c >= 0; c--) begin
                if (hit[r][c]) begin
                    row_col[r] = IDX_W'(c);
                end
            end
        end
    end

    // Pick the topmost row with a hit
    always_comb begin
        o_loc.found = |row_hit;
        o_loc.row   = '0;
        o_loc.col   = '0;
        for (int r = SQ_DIM - 1; r >= 0; r--) begin
            if (row_hit[r]) begin
                o_loc.row = IDX_W'(r);
                o_loc.col = row_col[r];
            end
        end
    end

endmodule

>>> hdl/pfc_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Playfair lane merge
// Combines the two letter positions into the rule and the output pair.
// ----------------------------------------------------------------------------
module pfc_merge (
    input  pfc_pkg::t_square             i_square,
    input  pfc_pkg::t_loc                i_loc1,
    input  pfc_pkg::t_loc                i_loc2,
    input  logic                         i_decrypt,
    input  logic [pfc_pkg::CHAR_W-1:0]   i_raw1,
    input  logic [pfc_pkg::CHAR_W-1:0]   i_raw2,
    output pfc_pkg::t_result             o_result
);
    import pfc_pkg::*;

    logic [IDX_W-1:0] r1_n, c1_n, r2_n, c2_n;
    logic [IDX_W-1:0] r1_s, c1_s, r2_s, c2_s;
    t_rule            rule;

    // Work out the neighbour positions for both shift directions
    always_comb begin
        c1_s = i_decrypt ? wrap_dec(i_loc1.col) : wrap_inc(i_loc1.col);
        c2_s = i_decrypt ? wrap_dec(i_loc2.col) : wrap_inc(i_loc2.col);
        r1_s = i_decrypt ? wrap_dec(i_loc1.row) : wrap_inc(i_loc1.row);
        r2_s = i_decrypt ? wrap_dec(i_loc2.row) : wrap_inc(i_loc2.row);
    end

    // Choose the rule; a shared cell counts as the same row
    always_comb begin
        priority if (!(i_loc1.found && i_loc2.found)) begin
            rule = RULE_NONE;
        end else if (i_loc1.row == i_loc2.row) begin
            rule = RULE_ROW;
        end else if (i_loc1.col == i_loc2.col) begin
            rule = RULE_COL;
        end else begin
            rule = RULE_RECT;
        end
    end

    // Select the output cell positions
    always_comb begin
        unique case (rule)
            RULE_ROW: begin
                r1_n = i_loc1.row; c1_n = c1_s;
                r2_n = i_loc2.row; c2_n = c2_s;
            end
            RULE_COL: begin
                r1_n = r1_s; c1_n = i_loc1.col;
                r2_n = r2_s; c2_n = i_loc2.col;
            end
            RULE_RECT: begin
                r1_n = i_loc1.row; c1_n = i_loc2.col;
                r2_n = i_loc2.row; c2_n = i_loc1.col;
            end
            default: begin
                r1_n = '0; c1_n = '0;
                r2_n = '0; c2_n = '0;
            end
        endcase
    end

    // Read the cells, or pass the raw pair when a letter is missing
    always_comb begin
        o_result.rule = rule;
        if (rule == RULE_NONE) begin
            o_result.first  = i_raw1;
            o_result.second = i_raw2;
        end else begin
            o_result.first  = cell_char(i_square[r1_n][c1_n]);
            o_result.second = cell_char(i_square[r2_n][c2_n]);
        end
    end

endmodule

>>> hdl/playfair_digraph_cipher.sv
`timescale 1ns / 1ps
// Path: a pair accepted at a clock edge is registered in stage 1, stage 2 and the output
// register in turn before it is on the result ports.
// Throughput: one pair per cycle; busy never rises, so start may stay high.
// The depth is set by the prepare, locate (two 25-cell lanes) and merge stages.
// Reset clears the key square to code 0 and drops every item in flight.
// ----------------------------------------------------------------------------
// Playfair digraph cipher top level
// Prepares the pair, locates both letters in parallel lanes and merges the
// positions into the enciphered or deciphered pair.
// ----------------------------------------------------------------------------
`include "playfair_digraph_cipher_assert.svh"

module playfair_digraph_cipher (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_mode,
    input  logic [pfc_pkg::CHAR_W-1:0]      i_first_char,
    input  logic [pfc_pkg::CHAR_W-1:0]      i_second_char,
    input  logic                            i_final_pair,
    input  logic                            i_cfg_we,
    input  logic [pfc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [pfc_pkg::ROW_W-1:0]       i_cfg_data,
    output logic                            o_valid,
    output logic [pfc_pkg::CHAR_W-1:0]      o_first_out,
    output logic [pfc_pkg::CHAR_W-1:0]      o_second_out,
    output logic [1:0]                      o_rule_used,
    output logic                            o_final_pair_out
);
    import pfc_pkg::*;

    t_square           r_square;
    logic              accept;
    logic [CHAR_W-1:0] n_a, n_b;

    logic              r_s1_valid, r_s1_mode, r_s1_final;
    logic [CHAR_W-1:0] r_s1_a, r_s1_b, r_s1_raw1, r_s1_raw2;

    t_loc              loc1, loc2;
    logic              r_s2_valid, r_s2_mode, r_s2_final;
    t_loc              r_s2_loc1, r_s2_loc2;
    logic [CHAR_W-1:0] r_s2_raw1, r_s2_raw2;

    t_result           result;

    logic                s1_has_j, s2_miss;
    logic [2*CHAR_W-1:0] s2_raw_pair, out_pair;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Write key square rows; indexes past the last row are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_square <= '0;
        end else if (i_cfg_we) begin
            for (int r = 0; r < SQ_DIM; r++) begin
                if (i_cfg_idx == CFG_IDX_W'(r)) begin
                    r_square[r] <= i_cfg_data;
                end
            end
        end
    end

    // Prepare the pair when enciphering: filler on a double letter, then fold J into I
    always_comb begin
        n_a = i_first_char;
        n_b = i_second_char;
        if (!i_mode) begin
            if (i_first_char == i_second_char) begin
                n_b = CHAR_X;
            end
            if (n_a == CHAR_J) begin
                n_a = CHAR_I;
            end
            if (n_b == CHAR_J) begin
                n_b = CHAR_I;
            end
        end
    end

    // Stage 1: hold the prepared item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_mode  <= i_mode;
        r_s1_final <= i_final_pair;
        r_s1_a     <= n_a;
        r_s1_b     <= n_b;
        r_s1_raw1  <= i_first_char;
        r_s1_raw2  <= i_second_char;
    end

    // Locate each letter in its own lane
    pfc_lane u_lane1 (
        .i_square (r_square),
        .i_letter (r_s1_a),
        .o_loc    (loc1)
    );

    pfc_lane u_lane2 (
        .i_square (r_square),
        .i_letter (r_s1_b),
        .o_loc    (loc2)
    );

    // Stage 2: hold the lane positions
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_mode  <= r_s1_mode;
        r_s2_final <= r_s1_final;
        r_s2_loc1  <= loc1;
        r_s2_loc2  <= loc2;
        r_s2_raw1  <= r_s1_raw1;
        r_s2_raw2  <= r_s1_raw2;
    end

    // Merge the lanes into the result pair
    pfc_merge u_merge (
        .i_square  (r_square),
        .i_loc1    (r_s2_loc1),
        .i_loc2    (r_s2_loc2),
        .i_decrypt (r_s2_mode),
        .i_raw1    (r_s2_raw1),
        .i_raw2    (r_s2_raw2),
        .o_result  (result)
    );

    // Output register: strobe for one cycle per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        o_first_out      <= result.first;
        o_second_out     <= result.second;
        o_rule_used      <= result.rule;
        o_final_pair_out <= r_s2_final;
    end

    // Flags and packed pairs for the checks below
    assign s1_has_j    = (r_s1_a == CHAR_J) || (r_s1_b == CHAR_J);
    assign s2_miss     = r_s2_valid && !(r_s2_loc1.found && r_s2_loc2.found);
    assign s2_raw_pair = {r_s2_raw1, r_s2_raw2};
    assign out_pair    = {o_first_out, o_second_out};

    // Every accepted item is later marked by the output strobe
    `PFC_ASSERT_SAME(a_latency, i_clk, i_rst_n, accept, ##3 o_valid)
    // No strobe without an item in the last stage
    `PFC_ASSERT_NEXT(a_no_phantom, i_clk, i_rst_n, !r_s2_valid, !o_valid)
    // Encryption never lets a J reach the lanes
    `PFC_ASSERT_SAME(a_no_j, i_clk, i_rst_n, r_s1_valid && !r_s1_mode, !s1_has_j)
    // A missing letter gives the not-found code
    `PFC_ASSERT_NEXT(a_not_found, i_clk, i_rst_n, s2_miss, o_rule_used == RULE_NONE)
    // A missing letter passes the raw pair through
    `PFC_ASSERT_NEXT(a_raw_pass, i_clk, i_rst_n, s2_miss, out_pair == $past(s2_raw_pair))

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Playfair digraph cipher testbench
// Loads key squares through the register port and sends letter pairs through
// the start/busy handshake. Each accepted item gets its expected pair, rule
// and final flag from the directed table or from a local model of the cipher.
// Results are then compared in order as the strobe marks them. A short directed
// table comes first, then random phases under several key squares, all but one with bursty issue.
// ----------------------------------------------------------------------------
module tb;

    import pfc_pkg::*;

    typedef logic [CHAR_W-1:0]             char_t;
    typedef logic [SQ_DIM-1:0][ROW_W-1:0]  square_t;

    typedef struct packed {
        char_t first;
        char_t second;
        t_rule rule;
        logic  fin;
    } pair_result_t;

    typedef enum bit { STEP_PAIR, STEP_SQUARE } step_kind_t;

    typedef struct packed {
        step_kind_t   kind;
        logic         mode;
        char_t        a;
        char_t        b;
        logic         fin;
        logic         known;
        pair_result_t want;
        square_t      square;
    } step_t;

    localparam logic [CFG_IDX_W-1:0] REG_SQUARE_ROW0 = CFG_IDX_W'(0);
    localparam logic                 MODE_ENC        = 1'b0;
    localparam logic                 MODE_DEC        = 1'b1;
    localparam int                   SETTLE_CYCLES   = 6;
    localparam int                   DRAIN_LIMIT     = 200;

    logic                   i_clk;
    logic                   i_rst_n       = 1'b0;
    logic                   start         = 1'b0;
    logic                   busy;
    logic                   i_mode        = 1'b0;
    char_t                  i_first_char  = '0;
    char_t                  i_second_char = '0;
    logic                   i_final_pair  = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx     = '0;
    logic [ROW_W-1:0]       i_cfg_data    = '0;
    logic                   o_valid;
    char_t                  o_first_out;
    char_t                  o_second_out;
    logic [1:0]             o_rule_used;
    logic                   o_final_pair_out;

    square_t      key_rows = '0;
    pair_result_t pending_pairs[$];
    step_t        directed_steps[$];
    int           fails = 0;

    playfair_digraph_cipher u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_mode           (i_mode),
        .i_first_char     (i_first_char),
        .i_second_char    (i_second_char),
        .i_final_pair     (i_final_pair),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .o_valid          (o_valid),
        .o_first_out      (o_first_out),
        .o_second_out     (o_second_out),
        .o_rule_used      (o_rule_used),
        .o_final_pair_out (o_final_pair_out)
    );

    // 100 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop if the run hangs
    initial begin
        #2_000_000;
        $display("[playfair_digraph_cipher] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Cipher model
    // ------------------------------------------------------------------------

    // Letter held in one cell of the current key square
    function automatic char_t square_letter(input int r, input int c);
        square_letter = 8'h41 + {3'b000, key_rows[r][c*CODE_W +: CODE_W]};
    endfunction

    // First row-major cell holding the letter
    function automatic logic find_letter(input char_t ch, output int r, output int c);
        find_letter = 1'b0;
        r = 0;
        c = 0;
        for (int rr = SQ_DIM - 1; rr >= 0; rr--) begin
            for (int cc = SQ_DIM - 1; cc >= 0; cc--) begin
                if (square_letter(rr, cc) == ch) begin
                    find_letter = 1'b1;
                    r = rr;
                    c = cc;
                end
            end
        end
    endfunction

    function automatic pair_result_t cipher_pair(input logic dec, input char_t a_raw,
                                                 input char_t b_raw, input logic fin);
        char_t        a;
        char_t        b;
        int           r1, c1, r2, c2, shift;
        logic         f1, f2;
        pair_result_t res;
        a = a_raw;
        b = b_raw;
        // encryption splits doubled letters with X, then folds J into I
        if (!dec) begin
            if (a == b)
                b = CHAR_X;
            if (a == CHAR_J)
                a = CHAR_I;
            if (b == CHAR_J)
                b = CHAR_I;
        end
        f1 = find_letter(a, r1, c1);
        f2 = find_letter(b, r2, c2);
        shift = dec ? SQ_DIM - 1 : 1;
        res.fin = fin;
        if (!(f1 && f2)) begin
            res.first  = a_raw;
            res.second = b_raw;
            res.rule   = RULE_NONE;
        end else if (r1 == r2) begin
            res.first  = square_letter(r1, (c1 + shift) % SQ_DIM);
            res.second = square_letter(r2, (c2 + shift) % SQ_DIM);
            res.rule   = RULE_ROW;
        end else if (c1 == c2) begin
            res.first  = square_letter((r1 + shift) % SQ_DIM, c1);
            res.second = square_letter((r2 + shift) % SQ_DIM, c2);
            res.rule   = RULE_COL;
        end else begin
            res.first  = square_letter(r1, c2);
            res.second = square_letter(r2, c1);
            res.rule   = RULE_RECT;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Key squares
    // ------------------------------------------------------------------------

    // Pack 25 characters, row by row, column 0 in the low bits
    function automatic square_t square_of(input string s);
        square_t sq;
        for (int i = 0; i < SQ_DIM * SQ_DIM; i++)
            sq[i / SQ_DIM][(i % SQ_DIM)*CODE_W +: CODE_W] = CODE_W'(s[i] - 8'h41);
        return sq;
    endfunction

    // Standard 25-letter alphabet (no J) in random order
    function automatic square_t shuffled_square();
        logic [CODE_W-1:0] codes[SQ_DIM*SQ_DIM];
        logic [CODE_W-1:0] tmp;
        square_t           sq;
        int                k, j;
        k = 0;
        for (int code = 0; code < 26; code++) begin
            if (code != CHAR_J - 8'h41) begin
                codes[k] = CODE_W'(code);
                k++;
            end
        end
        for (int i = SQ_DIM * SQ_DIM - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = codes[i];
            codes[i] = codes[j];
            codes[j] = tmp;
        end
        for (int i = 0; i < SQ_DIM * SQ_DIM; i++)
            sq[i / SQ_DIM][(i % SQ_DIM)*CODE_W +: CODE_W] = codes[i];
        return sq;
    endfunction

    // Drain the pipe, then write all five rows
    task automatic load_square(input square_t sq);
        start <= 1'b0;
        while (pending_pairs.size() != 0)
            @(posedge i_clk);
        for (int i = 0; i < SQ_DIM; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= REG_SQUARE_ROW0 + CFG_IDX_W'(i);
            i_cfg_data <= sq[i];
            @(posedge i_clk);
            key_rows[i] = sq[i];
        end
        i_cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Item issue
    // ------------------------------------------------------------------------

    // Hold start until busy is low at an edge, then queue the expectation
    task automatic send_pair(input logic mode, input char_t a, input char_t b,
                             input logic fin, input logic known,
                             input pair_result_t want);
        start         <= 1'b1;
        i_mode        <= mode;
        i_first_char  <= a;
        i_second_char <= b;
        i_final_pair  <= fin;
        do
            @(posedge i_clk);
        while (busy !== 1'b0);
        pending_pairs.push_back(known ? want : cipher_pair(mode, a, b, fin));
    endtask

    // Mostly letters of the square, some J and some arbitrary bytes
    function automatic char_t pick_letter();
        case ($urandom_range(0, 9))
            0:       return char_t'($urandom_range(0, 255));
            1:       return CHAR_J;
            default: return square_letter($urandom_range(0, SQ_DIM - 1),
                                          $urandom_range(0, SQ_DIM - 1));
        endcase
    endfunction

    task automatic run_items(input int count, input bit bursty, input bit hold_mid);
        int           burst_left;
        char_t        a, b;
        pair_result_t none;
        burst_left = $urandom_range(1, 16);
        none = '0;
        for (int i = 0; i < count; i++) begin
            // hold off once until every result is back
            if (hold_mid && i == count / 2) begin
                start <= 1'b0;
                while (pending_pairs.size() != 0)
                    @(posedge i_clk);
            end
            a = pick_letter();
            b = ($urandom_range(0, 7) == 0) ? a : pick_letter();
            send_pair($urandom_range(0, 1), a, b, $urandom_range(0, 7) == 0, 1'b0, none);
            burst_left--;
            if (bursty && burst_left == 0) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                burst_left = $urandom_range(1, 16);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------------

    task automatic add_pair(input logic mode, input char_t a, input char_t b, input logic fin);
        step_t s;
        s = '0;
        s.kind = STEP_PAIR;
        s.mode = mode;
        s.a    = a;
        s.b    = b;
        s.fin  = fin;
        directed_steps.push_back(s);
    endtask

    task automatic add_known(input logic mode, input char_t a, input char_t b, input logic fin,
                             input char_t e1, input char_t e2, input t_rule rule);
        step_t s;
        s = '0;
        s.kind  = STEP_PAIR;
        s.mode  = mode;
        s.a     = a;
        s.b     = b;
        s.fin   = fin;
        s.known = 1'b1;
        s.want  = '{first: e1, second: e2, rule: rule, fin: fin};
        directed_steps.push_back(s);
    endtask

    task automatic add_square(input square_t sq);
        step_t s;
        s = '0;
        s.kind   = STEP_SQUARE;
        s.square = sq;
        directed_steps.push_back(s);
    endtask

    // ------------------------------------------------------------------------
    // Result check
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        pair_result_t want;
        if (i_rst_n && o_valid) begin
            if (pending_pairs.size() == 0) begin
                $error("result with no pair outstanding");
                fails++;
            end else begin
                want = pending_pairs.pop_front();
                if (o_first_out !== want.first) begin
                    $error("first_out: expected %h, got %h", want.first, o_first_out);
                    fails++;
                end
                if (o_second_out !== want.second) begin
                    $error("second_out: expected %h, got %h", want.second, o_second_out);
                    fails++;
                end
                if (o_rule_used !== want.rule) begin
                    $error("rule_used: expected %0d, got %0d", want.rule, o_rule_used);
                    fails++;
                end
                if (o_final_pair_out !== want.fin) begin
                    $error("final_pair_out: expected %0d, got %0d", want.fin, o_final_pair_out);
                    fails++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        square_t sq;
        int      drained;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // after reset every cell reads A
        add_known(MODE_ENC, "A", "B", 1'b0, "A", "B", RULE_NONE);
        add_known(MODE_ENC, "A", "A", 1'b0, "A", "A", RULE_NONE);
        add_known(MODE_DEC, "A", "A", 1'b1, "A", "A", RULE_ROW);
        add_known(MODE_ENC, 8'h00, 8'hFF, 1'b0, 8'h00, 8'hFF, RULE_NONE);
        add_known(MODE_DEC, 8'hFF, 8'h00, 1'b1, 8'hFF, 8'h00, RULE_NONE);
        // classic key square
        add_square(square_of("PLAYFIREXMBCDGHKNOQSTUVWZ"));
        add_pair(MODE_ENC, "P", "A", 1'b0);    // same row
        add_pair(MODE_DEC, "L", "F", 1'b0);    // same row, shift left
        add_pair(MODE_ENC, "F", "Z", 1'b0);    // same column, wrap down
        add_pair(MODE_DEC, "P", "I", 1'b0);    // same column, wrap up
        add_pair(MODE_ENC, "H", "I", 1'b0);    // rectangle
        add_pair(MODE_DEC, "B", "M", 1'b1);    // rectangle
        add_pair(MODE_ENC, "J", "K", 1'b0);    // J folded into I
        add_pair(MODE_ENC, "E", "J", 1'b0);
        add_pair(MODE_ENC, "L", "L", 1'b0);    // doubled letter split by X
        add_pair(MODE_ENC, "X", "X", 1'b0);    // split lands in the same cell
        add_pair(MODE_ENC, "J", "J", 1'b0);
        add_pair(MODE_DEC, "J", "A", 1'b0);    // no J fold when deciphering
        add_pair(MODE_ENC, "a", "b", 1'b1);    // lower case is not found
        add_pair(MODE_DEC, "E", "E", 1'b0);    // both letters in one cell
        // every cell at the top code
        add_square({SQ_DIM{{ROW_W{1'b1}}}});
        add_known(MODE_DEC, 8'h60, 8'h60, 1'b1, 8'h60, 8'h60, RULE_ROW);
        add_known(MODE_ENC, 8'h60, "A", 1'b0, 8'h60, "A", RULE_NONE);
        // codes past Z and duplicate cells
        add_square(square_of("[\\]^_`AAB[CDEFGHIKLMNOPQR"));
        add_pair(MODE_ENC, "[", "_", 1'b0);
        add_pair(MODE_DEC, 8'h60, "[", 1'b0);
        add_pair(MODE_ENC, "A", "B", 1'b1);

        // walk the table
        foreach (directed_steps[i]) begin
            if (directed_steps[i].kind == STEP_SQUARE)
                load_square(directed_steps[i].square);
            else
                send_pair(directed_steps[i].mode, directed_steps[i].a, directed_steps[i].b,
                          directed_steps[i].fin, directed_steps[i].known,
                          directed_steps[i].want);
        end

        // random phases, one key square each
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                2, 4:    for (int r = 0; r < SQ_DIM; r++) sq[r] = ROW_W'($urandom);
                5:       sq = {SQ_DIM{{ROW_W{1'b1}}}};
                6:       sq = '0;
                default: sq = shuffled_square();
            endcase
            load_square(sq);
            run_items(ph >= 5 ? 25 : 90, ph != 1, ph == 0);
        end

        // drain and settle
        start <= 1'b0;
        drained = 0;
        while (pending_pairs.size() != 0 && drained < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drained++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_pairs.size() != 0) begin
            $error("%0d results never arrived", pending_pairs.size());
            fails++;
        end

        if (fails == 0) begin
            $display("[playfair_digraph_cipher] OK");
        end else begin
            $display("[playfair_digraph_cipher] ERROR");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+hdl
hdl/pfc_pkg.sv
hdl/pfc_lane.sv
hdl/pfc_merge.sv
hdl/playfair_digraph_cipher.sv
tb/tb.sv
